// ===== design/mdu_pkg.sv =====
// Package for the RV32M multiply/divide unit: opcodes, widths, cell payload type.
// No dependencies.
package mdu_pkg;
    localparam int XLEN = 32;
    localparam int NCELL = 32;

    typedef enum logic [2:0] {
        OP_MUL    = 3'd0,
        OP_MULH   = 3'd1,
        OP_MULHSU = 3'd2,
        OP_MULHU  = 3'd3,
        OP_DIV    = 3'd4,
        OP_DIVU   = 3'd5,
        OP_REM    = 3'd6,
        OP_REMU   = 3'd7
    } t_op;

    // one beat in flight through the cell row
    typedef struct packed {
        logic                valid;
        logic [2:0]          op;
        logic [4:0]          rd;
        logic                neg_q;    // negate quotient/product at the end
        logic                neg_r;    // negate remainder at the end
        logic                special;  // div by zero or overflow: use fixed result
        logic [XLEN-1:0]     fixed;
        logic [XLEN-1:0]     mb;       // divisor magnitude / multiplicand
        logic [2*XLEN-1:0]   acc;      // {rem, quotient} or product accumulator
        logic [XLEN-1:0]     mq;       // dividend bits left / multiplier bits left
    } t_beat;
endpackage

// ===== design/mdu_cell.sv =====
// One cell of the row: a restoring divide step or a shift-add multiply step.
// Depends on mdu_pkg.
module mdu_cell import mdu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_beat i_beat,
    output t_beat o_beat
);
    t_beat n_beat, r_beat;
    logic [XLEN:0] w_trial;
    logic [XLEN-1:0] w_rem;
    logic [XLEN:0] w_sum;

    always_comb begin
        n_beat = i_beat;
        w_rem = i_beat.acc[2*XLEN-1:XLEN];
        w_trial = {w_rem[XLEN-1:0], i_beat.mq[XLEN-1]} - {1'b0, i_beat.mb};
        w_sum = {1'b0, i_beat.acc[2*XLEN-1:XLEN]}
              + (i_beat.mq[0] ? {1'b0, i_beat.mb} : '0);
        if (i_beat.op[2]) begin
            n_beat.mq = {i_beat.mq[XLEN-2:0], 1'b0};
            if (!w_trial[XLEN])
                n_beat.acc = {w_trial[XLEN-1:0], i_beat.acc[XLEN-2:0], 1'b1};
            else
                n_beat.acc = {w_rem[XLEN-2:0], i_beat.mq[XLEN-1],
                              i_beat.acc[XLEN-2:0], 1'b0};
        end else begin
            n_beat.mq = {1'b0, i_beat.mq[XLEN-1:1]};
            n_beat.acc = {w_sum, i_beat.acc[XLEN-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;
endmodule

// ===== design/rv32m_multiply_divide_unit.sv =====
// RV32M multiply/divide unit: 32 pipelined cells, one operand bit each.
// Beats pass through a prep register, 32 cells and a finish register.
// Throughput one beat per cycle; the whole row stalls when the output stalls.
// Synchronous active-low reset clears all valid flags; no clearing pass.
// Depends on mdu_pkg and mdu_cell.
module rv32m_multiply_divide_unit import mdu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] operation, [34:3] operand_a, [66:35] operand_b, [71:67] dest_index
    input  logic [71:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] result_value, [32] write_enable, [37:33] write_index
    output logic [39:0] o_m_tdata
);
    logic [2:0] w_op;
    logic [XLEN-1:0] w_a, w_b, w_ma, w_mb;
    logic [4:0] w_rd;
    logic w_sa, w_sb, w_en;
    t_beat n_in, r_in;
    t_beat w_chain [NCELL+1];
    logic r_ov;
    logic [39:0] r_out;
    logic [XLEN-1:0] w_res, w_q, w_r;
    t_beat w_last;

    assign w_op = i_s_tdata[2:0];
    assign w_a = i_s_tdata[34:3];
    assign w_b = i_s_tdata[66:35];
    assign w_rd = i_s_tdata[71:67];
    assign w_en = !r_ov || i_m_tready;
    assign o_s_tready = w_en;

    always_comb begin
        w_sa = w_a[XLEN-1] && (w_op == OP_MULH || w_op == OP_MULHSU
                             || w_op == OP_DIV || w_op == OP_REM);
        w_sb = w_b[XLEN-1] && (w_op == OP_MULH || w_op == OP_DIV || w_op == OP_REM);
        w_ma = w_sa ? -w_a : w_a;
        w_mb = w_sb ? -w_b : w_b;
        n_in = '0;
        n_in.valid = i_s_tvalid;
        n_in.op = w_op;
        n_in.rd = w_rd;
        n_in.neg_q = w_sa ^ w_sb;
        n_in.neg_r = w_sa;
        n_in.mb = w_op[2] ? w_mb : w_mb;
        n_in.mq = w_ma;
        n_in.acc = '0;
        if (w_op[2] && w_b == '0) begin
            n_in.special = 1'b1;
            n_in.fixed = w_op[1] ? w_a : '1;
        end else if ((w_op == OP_DIV || w_op == OP_REM) && w_a == {1'b1, {XLEN-1{1'b0}}}
                     && w_b == '1) begin
            n_in.special = 1'b1;
            n_in.fixed = w_op[1] ? '0 : w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    assign w_chain[0] = r_in;
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        mdu_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_beat (w_chain[g]),
            .o_beat (w_chain[g+1])
        );
    end

    assign w_last = w_chain[NCELL];
    always_comb begin
        logic [2*XLEN-1:0] p;
        p = w_last.neg_q ? -w_last.acc : w_last.acc;
        w_q = w_last.neg_q ? -w_last.acc[XLEN-1:0] : w_last.acc[XLEN-1:0];
        w_r = w_last.neg_r ? -w_last.acc[2*XLEN-1:XLEN] : w_last.acc[2*XLEN-1:XLEN];
        case (w_last.op)
            OP_MUL: w_res = p[XLEN-1:0];
            OP_MULH, OP_MULHSU, OP_MULHU: w_res = p[2*XLEN-1:XLEN];
            OP_DIV, OP_DIVU: w_res = w_q;
            default: w_res = w_r;
        endcase
        if (w_last.special) w_res = w_last.fixed;
        if (w_last.rd == '0) w_res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_last.valid;
            r_out <= {2'b00, w_last.rd, w_last.rd != '0, w_res};
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata = r_out;
endmodule

// ===== design/mdu_checker.sv =====
// Port-level checker for the multiply/divide unit, bound to the top level.
// Depends on rv32m_multiply_divide_unit ports only.
module mdu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat changed under stall");
    a_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[32] == (o_m_tdata[37:33] != 5'd0))
        else $error("write enable disagrees with index");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[32] |-> o_m_tdata[31:0] == 32'd0)
        else $error("suppressed write carries data");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");
endmodule

bind rv32m_multiply_divide_unit mdu_checker u_mdu_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);
